// File: src/wsh_pkg.sv
// ----------------------------------------------------------------------------
// wsh_pkg
// shared types, constants and md5 tables for the weighted simhash block
// ----------------------------------------------------------------------------
package wsh_pkg;

    localparam int LEN_W    = 13;      // document length width
    localparam int TEXT_MAX = 4096;    // saturation for the document length
    localparam int ACC_W    = 34;      // accumulator width
    localparam int WT_W     = 21;      // scaled weight width
    localparam int LANES    = 8;       // accumulators per memory row
    localparam int ROWS     = 16;      // memory rows
    localparam int ROW_AW   = 4;
    localparam int CNT_W    = 5;       // pass counter, counts to ROWS
    localparam int FP_W     = 128;

    localparam logic [31:0] MD5_A0 = 32'h67452301;
    localparam logic [31:0] MD5_B0 = 32'hefcdab89;
    localparam logic [31:0] MD5_C0 = 32'h98badcfe;
    localparam logic [31:0] MD5_D0 = 32'h10325476;

    localparam logic [0:0] REG_CENTER_WEIGHT = 1'b0;
    localparam logic [7:0] CENTER_WEIGHT_RST = 8'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_ACC,
        ST_LOAD
    } state_t;

    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [3:0] idx);
        logic [4:0] s;
        case (idx)
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

// File: src/wsh_ram.sv
// ----------------------------------------------------------------------------
// wsh_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/wsh_md5.sv
// ----------------------------------------------------------------------------
// wsh_md5
// iterative md5 of a two-byte message, one round per cycle
// ----------------------------------------------------------------------------
module wsh_md5 (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [15:0]  code,
    output logic         done,
    output logic [127:0] digest
);

    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [31:0]  b_next;
    logic [15:0]  code_reg;
    logic [5:0]   round_reg;
    logic         run_reg;
    logic         done_reg;
    logic [127:0] digest_reg;

    logic [31:0] f;
    logic [3:0]  g;
    logic [31:0] m;
    logic [31:0] t;
    logic [4:0]  s;
    logic [63:0] rot;

    always_comb
    begin
        case (round_reg[5:4])
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = round_reg[3:0];
            end
            2'd1:
            begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(round_reg[3:0] * 4'd5 + 4'd1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(round_reg[3:0] * 4'd3 + 4'd5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(round_reg[3:0] * 4'd7);
            end
        endcase
        // message: bytes lo, hi, padding 0x80, bit length 16
        if (g == 4'd0)
        begin
            m = {8'h00, 8'h80, code_reg};
        end
        else if (g == 4'd14)
        begin
            m = 32'd16;
        end
        else
        begin
            m = 32'd0;
        end
        t      = f + a_reg + wsh_pkg::md5_k(round_reg) + m;
        s      = wsh_pkg::md5_s({round_reg[5:4], round_reg[1:0]});
        rot    = {t, t} << s;
        b_next = b_reg + rot[63:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg   <= 1'b1;
                round_reg <= '0;
            end
            else if (run_reg)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= wsh_pkg::MD5_A0;
            b_reg    <= wsh_pkg::MD5_B0;
            c_reg    <= wsh_pkg::MD5_C0;
            d_reg    <= wsh_pkg::MD5_D0;
            code_reg <= code;
        end
        else if (run_reg)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_next;
            if (round_reg == 6'd63)
            begin
                digest_reg <= {wsh_pkg::MD5_D0 + c_reg, wsh_pkg::MD5_C0 + b_reg,
                               wsh_pkg::MD5_B0 + b_next, wsh_pkg::MD5_A0 + d_reg};
            end
        end
    end

    assign done   = done_reg;
    assign digest = digest_reg;

endmodule

// File: src/weighted_simhash_fingerprint.sv
// ----------------------------------------------------------------------------
// weighted_simhash_fingerprint
// position weighted 128-bit simhash over md5 of 16-bit characters
// ----------------------------------------------------------------------------
//  channel   dir  handshake          content
//  s_*       in   tvalid/tready      char_code, text_length, last_char (tlast)
//  m_*       out  tvalid/tready      fingerprint_half, half_index (tuser), run_end (tlast)
//  apb       in   psel/penable       center_weight at byte address 0
//
//  a counted character is accepted, hashed in 64 md5 rounds and then accumulated
//  in a pass over the 16-row accumulator memory
//  an ignored character is only accepted; one with tlast also runs the pass
//  reset clears row valid bits, so the accumulators read as zero without a sweep
//  the result words sit in an output buffer; a later tlast waits only if it is full
module weighted_simhash_fingerprint (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [15:0] char_code, [28:16] text_length
    input  logic        s_tlast,     // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [63:0] fingerprint_half
    output logic [0:0]  m_tuser,     // [0] half_index
    output logic        m_tlast,     // run_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW = wsh_pkg::LEN_W;
    localparam int AW = wsh_pkg::ACC_W;
    localparam int RW = wsh_pkg::ACC_W * wsh_pkg::LANES;

    wsh_pkg::state_t state_reg, state_next;

    logic [7:0]    center_weight_reg;
    logic [LW-1:0] pos_reg;          // characters taken in this document
    logic [LW-1:0] item_pos_reg;
    logic [LW-1:0] item_len_reg;
    logic          item_take_reg;
    logic          item_last_reg;
    logic [wsh_pkg::WT_W-1:0] weight_reg;
    logic [wsh_pkg::CNT_W-1:0] acc_cnt_reg;
    logic          rd_valid_reg;
    logic [wsh_pkg::ROWS-1:0] row_valid_reg;
    logic [wsh_pkg::FP_W-1:0] sign_reg;
    logic [wsh_pkg::FP_W-1:0] out_fp_reg;
    logic          out_busy_reg;
    logic          out_half_reg;

    // input decode
    logic          s_acc;
    logic [LW-1:0] in_len;
    logic [LW-1:0] len_sat;
    logic          in_take;

    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == wsh_pkg::ST_IDLE);
    assign in_len   = s_tdata[16 +: LW];
    assign len_sat  = (in_len > LW'(wsh_pkg::TEXT_MAX)) ? LW'(wsh_pkg::TEXT_MAX) : in_len;
    assign in_take  = (pos_reg < len_sat);

    // config port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == wsh_pkg::REG_CENTER_WEIGHT) ? {24'd0, center_weight_reg} : 32'd0;

    // md5 unit
    logic         md5_done;
    logic [127:0] digest;

    wsh_md5 u_md5 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (s_acc && in_take),
        .code   (s_tdata[15:0]),
        .done   (md5_done),
        .digest (digest)
    );

    // weight: one shared multiplier for the ramp and the center plateau
    logic [LW-1:0] p;
    logic [LW-1:0] n8;
    logic [LW-1:0] n38;
    logic          on_ramp;
    logic [LW-1:0] mul_a;
    logic [9:0]    mul_b;
    logic [22:0]   prod;
    logic [wsh_pkg::WT_W-1:0] weight_next;

    always_comb
    begin
        p       = (item_pos_reg < (item_len_reg >> 1)) ? item_pos_reg + LW'(1)
                                                       : item_len_reg - item_pos_reg;
        n8      = item_len_reg >> 3;
        n38     = LW'(((LW + 2)'(item_len_reg) * (LW + 2)'(3)) >> 3);
        on_ramp = (p < n38);
        mul_a   = on_ramp ? (p - n8) : item_len_reg;
        mul_b   = on_ramp ? {center_weight_reg, 2'b00} : 10'(center_weight_reg) + 10'd1;
        prod    = 23'(mul_a) * 23'(mul_b);
        if (p < n8)
        begin
            weight_next = wsh_pkg::WT_W'(item_len_reg);
        end
        else if (on_ramp)
        begin
            weight_next = wsh_pkg::WT_W'(prod + 23'(item_len_reg));
        end
        else
        begin
            weight_next = wsh_pkg::WT_W'(prod);
        end
    end

    // accumulator memory: read row cnt, update and write row cnt-1
    logic [wsh_pkg::ROW_AW-1:0] rd_row;
    logic [wsh_pkg::ROW_AW-1:0] wr_row;
    logic          wr_phase;
    logic [RW-1:0] rdata;
    logic [RW-1:0] wdata;
    logic [wsh_pkg::LANES-1:0] row_sign;

    assign rd_row   = acc_cnt_reg[wsh_pkg::ROW_AW-1:0];
    assign wr_row   = wsh_pkg::ROW_AW'(acc_cnt_reg - wsh_pkg::CNT_W'(1));
    assign wr_phase = (state_reg == wsh_pkg::ST_ACC) && (acc_cnt_reg != '0);

    always_comb
    begin
        logic [AW-1:0] old_v;
        logic [AW-1:0] new_v;
        for (int l = 0; l < wsh_pkg::LANES; l++)
        begin
            old_v = rd_valid_reg ? rdata[l*AW +: AW] : '0;
            if (!item_take_reg)
            begin
                new_v = old_v;
            end
            else if (digest[{wr_row, 3'(l)}])
            begin
                new_v = old_v + AW'(weight_reg);
            end
            else
            begin
                new_v = old_v - AW'(weight_reg);
            end
            wdata[l*AW +: AW] = new_v;
            row_sign[l]       = !new_v[AW-1] && (new_v != '0);
        end
    end

    wsh_ram #(
        .WIDTH (RW),
        .DEPTH (wsh_pkg::ROWS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (wr_phase && item_take_reg),
        .waddr (wr_row),
        .wdata (wdata),
        .raddr (rd_row),
        .rdata (rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wsh_pkg::ST_IDLE:
            begin
                if (s_acc && in_take)
                begin
                    state_next = wsh_pkg::ST_HASH;
                end
                else if (s_acc && s_tlast)
                begin
                    state_next = wsh_pkg::ST_ACC;
                end
            end
            wsh_pkg::ST_HASH:
            begin
                if (md5_done)
                begin
                    state_next = wsh_pkg::ST_ACC;
                end
            end
            wsh_pkg::ST_ACC:
            begin
                if (acc_cnt_reg == wsh_pkg::CNT_W'(wsh_pkg::ROWS))
                begin
                    state_next = item_last_reg ? wsh_pkg::ST_LOAD : wsh_pkg::ST_IDLE;
                end
            end
            wsh_pkg::ST_LOAD:
            begin
                if (!out_busy_reg)
                begin
                    state_next = wsh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wsh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= wsh_pkg::ST_IDLE;
            center_weight_reg <= wsh_pkg::CENTER_WEIGHT_RST;
            pos_reg           <= '0;
            acc_cnt_reg       <= '0;
            row_valid_reg     <= '0;
            out_busy_reg      <= 1'b0;
            out_half_reg      <= 1'b0;
            item_take_reg     <= 1'b0;
            item_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr && (paddr[2] == wsh_pkg::REG_CENTER_WEIGHT))
            begin
                center_weight_reg <= pwdata[7:0];
            end
            if (s_acc)
            begin
                item_take_reg <= in_take;
                item_last_reg <= s_tlast;
                acc_cnt_reg   <= '0;
                if (s_tlast)
                begin
                    pos_reg <= '0;
                end
                else if (in_take)
                begin
                    pos_reg <= pos_reg + LW'(1);
                end
            end
            if (state_reg == wsh_pkg::ST_ACC)
            begin
                acc_cnt_reg <= acc_cnt_reg + wsh_pkg::CNT_W'(1);
                // document done: every accumulator back to zero
                if ((acc_cnt_reg == wsh_pkg::CNT_W'(wsh_pkg::ROWS)) && item_last_reg)
                begin
                    row_valid_reg <= '0;
                end
                else if (wr_phase && item_take_reg)
                begin
                    row_valid_reg[wr_row] <= 1'b1;
                end
            end
            // output buffer: two words, low half first
            if (m_tvalid && m_tready)
            begin
                if (out_half_reg)
                begin
                    out_busy_reg <= 1'b0;
                    out_half_reg <= 1'b0;
                end
                else
                begin
                    out_half_reg <= 1'b1;
                end
            end
            if ((state_reg == wsh_pkg::ST_LOAD) && !out_busy_reg)
            begin
                out_busy_reg <= 1'b1;
                out_half_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            item_pos_reg <= pos_reg;
            item_len_reg <= len_sat;
        end
        if (state_reg == wsh_pkg::ST_HASH)
        begin
            weight_reg <= weight_next;
        end
        if (state_reg == wsh_pkg::ST_ACC)
        begin
            rd_valid_reg <= row_valid_reg[rd_row];
        end
        if (wr_phase)
        begin
            sign_reg[{wr_row, 3'd0} +: wsh_pkg::LANES] <= row_sign;
        end
        if ((state_reg == wsh_pkg::ST_LOAD) && !out_busy_reg)
        begin
            out_fp_reg <= sign_reg;
        end
    end

    assign m_tvalid   = out_busy_reg;
    assign m_tdata    = out_half_reg ? out_fp_reg[127:64] : out_fp_reg[63:0];
    assign m_tuser[0] = out_half_reg;
    assign m_tlast    = out_half_reg;

    // checks
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != wsh_pkg::ST_IDLE) |-> !s_tready)
        else $error("input taken while an item is in progress");

    a_md5_only_hash: assert property (@(posedge clk) disable iff (!rst_n)
        md5_done |-> (state_reg == wsh_pkg::ST_HASH))
        else $error("digest finished outside the hash phase");

    a_first_half_low: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_busy_reg) |-> !out_half_reg)
        else $error("fingerprint started on the upper half");

    a_load_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wsh_pkg::ST_LOAD) && out_busy_reg |=> (state_reg == wsh_pkg::ST_LOAD))
        else $error("fingerprint buffer overwritten");

endmodule
